@@ hw/rtl/xsmw_pkg.sv @@
package xsmw_pkg;

	// Generator word geometry.
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned WORD_COUNT = 4;
	localparam int unsigned IDX_W      = $clog2(WORD_COUNT);
	localparam int unsigned MODE_W     = 2;

	// Seed chain constants.
	localparam logic [WORD_W-1:0] KNUTH_MULT  = 32'd1812433253;
	localparam int unsigned       KNUTH_SHIFT = 30;

	// Width mode codes of the configuration register.
	localparam logic [MODE_W-1:0] MODE_64  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_96  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_128 = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RESET = MODE_128;

	// Request type codes.
	localparam logic REQ_SEED = 1'b0;
	localparam logic REQ_NEXT = 1'b1;

	// Register map.
	localparam int unsigned PADDR_W = 3;
	localparam logic [0:0] REG_WIDTH_MODE = 1'b0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load_seed;
		logic             seed_step;
		logic [IDX_W-1:0] seed_idx;
		logic             step_next;
		logic             load_out;
		logic             load_skid;
		logic             skid_to_out;
	} xsmw_cmd_t;

	// The unused code behaves as the 128-bit mode.
	function automatic logic [MODE_W-1:0] active_mode(input logic [MODE_W-1:0] mode);
		return (mode == 2'd3) ? MODE_128 : mode;
	endfunction

	// Index of the last active word.
	function automatic logic [IDX_W-1:0] last_index(input logic [MODE_W-1:0] mode);
		logic [MODE_W-1:0] m;
		m = active_mode(mode);
		return IDX_W'(m) + IDX_W'(1);
	endfunction

endpackage

@@ hw/rtl/xsmw_ctrl.sv @@
module xsmw_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [xsmw_pkg::MODE_W-1:0] mode,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	output logic                        out_valid,
	input  logic                        out_ready,
	output xsmw_pkg::xsmw_cmd_t         cmd
);
	import xsmw_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_SEED
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic             skid_valid_q;
	logic             in_fire;
	logic             out_fire;
	logic             next_fire;
	logic             seed_fire;
	logic             seed_done;

	// Handshake decode.
	assign in_ready  = (state_q == ST_IDLE) && !skid_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid_q && out_ready;
	assign next_fire = in_fire && (req_type == REQ_NEXT);
	assign seed_fire = in_fire && (req_type == REQ_SEED);
	assign seed_done = (state_q == ST_SEED) && (idx_q == last_index(mode));
	assign out_valid = out_valid_q;

	// Commands for the datapath.
	always_comb begin
		cmd.load_seed   = seed_fire;
		cmd.seed_step   = (state_q == ST_SEED);
		cmd.seed_idx    = idx_q;
		cmd.step_next   = next_fire;
		cmd.load_out    = next_fire && (!out_valid_q || out_ready);
		cmd.load_skid   = next_fire && out_valid_q && !out_ready;
		cmd.skid_to_out = skid_valid_q && out_fire;
	end

	// State, seed word counter and result occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (seed_fire) begin
						state_q <= ST_SEED;
						idx_q   <= '0;
					end
				end
				ST_SEED: begin
					idx_q <= idx_q + IDX_W'(1);
					if (seed_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			out_valid_q  <= cmd.load_out || cmd.skid_to_out || (out_valid_q && !out_ready);
			skid_valid_q <= cmd.load_skid || (skid_valid_q && !out_fire);
		end
	end

endmodule

@@ hw/rtl/xsmw_dp.sv @@
module xsmw_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [xsmw_pkg::MODE_W-1:0] mode,
	input  logic [xsmw_pkg::WORD_W-1:0] seed_value,
	input  xsmw_pkg::xsmw_cmd_t         cmd,
	output logic [xsmw_pkg::WORD_W-1:0] random_value
);
	import xsmw_pkg::*;

	logic [WORD_W-1:0] words_q [WORD_COUNT];
	logic [WORD_W-1:0] chain_q;
	logic [WORD_W-1:0] out_q;
	logic [WORD_W-1:0] skid_q;
	logic [IDX_W-1:0]  last;
	logic [MODE_W-1:0] amode;
	logic [WORD_W-1:0] t_word;
	logic [WORD_W-1:0] z_word;
	logic [WORD_W-1:0] u_word;
	logic [WORD_W-1:0] next_word;
	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] seed_word;

	assign amode = active_mode(mode);
	assign last  = last_index(mode);

	// Xorshift step with the shift triple of the active width.
	always_comb begin
		t_word = words_q[0];
		z_word = words_q[last];
		unique case (amode)
			MODE_64: begin
				u_word    = t_word ^ (t_word << 10);
				next_word = (z_word ^ (z_word >> 10)) ^ (u_word ^ (u_word >> 13));
			end
			MODE_96: begin
				u_word    = t_word ^ (t_word << 10);
				next_word = (z_word ^ (z_word >> 26)) ^ (u_word ^ (u_word >> 1));
			end
			default: begin
				u_word    = t_word ^ (t_word << 11);
				next_word = (z_word ^ (z_word >> 19)) ^ (u_word ^ (u_word >> 8));
			end
		endcase
	end

	// One link of the seed chain: one 32x32 multiply and an add.
	assign mix       = chain_q ^ (chain_q >> KNUTH_SHIFT);
	assign seed_word = (KNUTH_MULT * mix) + WORD_W'(cmd.seed_idx) + WORD_W'(1);

	// Generator words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORD_COUNT; i++) begin
				words_q[i] <= '0;
			end
		end else if (cmd.step_next) begin
			for (int i = 0; i < WORD_COUNT - 1; i++) begin
				if (IDX_W'(i) < last) begin
					words_q[i] <= words_q[i+1];
				end
			end
			words_q[last] <= next_word;
		end else if (cmd.seed_step) begin
			words_q[cmd.seed_idx] <= seed_word;
		end
	end

	// Seed chain register and result buffers.
	always_ff @(posedge clk) begin
		if (cmd.load_seed) begin
			chain_q <= seed_value;
		end else if (cmd.seed_step) begin
			chain_q <= seed_word;
		end
		if (cmd.load_out) begin
			out_q <= next_word;
		end else if (cmd.skid_to_out) begin
			out_q <= skid_q;
		end
		if (cmd.load_skid) begin
			skid_q <= next_word;
		end
	end

	assign random_value = out_q;

endmodule

@@ hw/rtl/xorshift_multi_width_prng_core.sv @@
// Xorshift pseudo-random generator with a 64, 96 or 128-bit state chosen by
// the width_mode register (address 0, reset value 2 = 128 bits; code 3 acts
// as 2). An input transaction with req_type 1 returns one 32-bit word; it is
// computed in the cycle it is accepted; next requests run at one per cycle
// while the output buffer has room; its two entries let one more be taken
// while a result waits. A req_type 0 transaction seeds the active words
// from seed_value and returns nothing; the single 32x32 multiplier produces
// one word per cycle, so a seed request holds the input until all active
// words are written. The state resets to zero, so zeros are returned until
// the generator is seeded. Write width_mode only while the block is idle.
module xorshift_multi_width_prng_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [xsmw_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic [xsmw_pkg::WORD_W-1:0]  seed_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [xsmw_pkg::WORD_W-1:0]  random_value
);
	import xsmw_pkg::*;

	logic [MODE_W-1:0] width_mode_q;
	xsmw_cmd_t         cmd;
	logic              reg_hit;

	// Configuration register access.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1] == REG_WIDTH_MODE);
	assign prdata  = reg_hit ? {{(32-MODE_W){1'b0}}, width_mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_mode_q <= MODE_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			width_mode_q <= pwdata[MODE_W-1:0];
		end
	end

	// Sequencing and result handshake.
	xsmw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (width_mode_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Generator words, seed chain and result registers.
	xsmw_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (width_mode_q),
		.seed_value   (seed_value),
		.cmd          (cmd),
		.random_value (random_value)
	);

endmodule

@@ bench/xorshift_multi_width_prng_core_test.sv @@
module xorshift_multi_width_prng_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	import xsmw_pkg::*;

	// The unused width code, which the block treats as the 128-bit mode.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [PADDR_W-1:0] WIDTH_MODE_ADDR = PADDR_W'(4 * REG_WIDTH_MODE);
	// Cycles to let a seed chain finish after the last result has come.
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned ITEMS_PER_PHASE = 284;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_ready;
	logic req_type;
	logic [WORD_W-1:0] seed_value;
	logic out_valid;
	logic out_ready;
	logic [WORD_W-1:0] random_value;

	// Local copy of the generator state and of the width register.
	logic [WORD_W-1:0] gen_words [WORD_COUNT];
	logic [MODE_W-1:0] width_cfg;
	logic [WORD_W-1:0] expected_words [$];

	int unsigned send_idle_pct = 33;
	int unsigned recv_stall_pct = 75;
	int unsigned error_count = 0;

	xorshift_multi_width_prng_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.seed_value   (seed_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.random_value (random_value)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Apply one accepted request to the local generator and queue any word it returns.
	function automatic void advance_generator(input logic req, input logic [WORD_W-1:0] seed);
		logic [MODE_W-1:0] eff_mode;
		int unsigned word_count;
		int unsigned last;
		int unsigned sa;
		int unsigned sb;
		int unsigned sc;
		int unsigned i;
		logic [WORD_W-1:0] p;
		logic [WORD_W-1:0] t;
		logic [WORD_W-1:0] z;
		logic [WORD_W-1:0] r;
		eff_mode = (width_cfg == MODE_UNUSED) ? MODE_128 : width_cfg;
		word_count = int'(eff_mode) + 2;
		last = word_count - 1;
		if (req == REQ_SEED) begin
			p = seed;
			for (i = 0; i < word_count; i++) begin
				p = KNUTH_MULT * (p ^ (p >> KNUTH_SHIFT)) + WORD_W'(i + 1);
				gen_words[i] = p;
			end
		end else begin
			case (eff_mode)
				MODE_64: begin
					sa = 10; sb = 13; sc = 10;
				end
				MODE_96: begin
					sa = 10; sb = 1; sc = 26;
				end
				default: begin
					sa = 11; sb = 8; sc = 19;
				end
			endcase
			t = gen_words[0];
			z = gen_words[last];
			for (i = 0; i < last; i++)
				gen_words[i] = gen_words[i + 1];
			t = t ^ (t << sa);
			r = (z ^ (z >> sc)) ^ (t ^ (t >> sb));
			gen_words[last] = r;
			expected_words.push_back(r);
		end
	endfunction

	// Offer one request, with random idle cycles first, and track it once accepted.
	task automatic send_request(input logic req, input logic [WORD_W-1:0] seed);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		seed_value <= seed;
		do @(posedge clk); while (!in_ready);
		advance_generator(req, seed);
	endtask

	// Stop sending and wait until every expected word has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_words.size() != 0);
	endtask

	// Bring the block to idle, including any seed chain still running.
	task automatic wait_idle();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write over the configuration port: setup cycle, then access cycle.
	task automatic write_width_mode(input logic [MODE_W-1:0] mode);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= WIDTH_MODE_ADDR;
		pwdata <= 32'(mode);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		width_cfg = mode;
	endtask

	// The generator comes out of reset with all words zero and returns zeros.
	task automatic test_unseeded_zeros();
		send_request(REQ_NEXT, 32'hFFFF_FFFF);
		send_request(REQ_NEXT, 32'h0000_0000);
	endtask

	// Seeds at both ends of the range in the reset width.
	task automatic test_seed_extremes();
		send_request(REQ_SEED, 32'h0000_0000);
		send_request(REQ_NEXT, 32'h0000_0000);
		send_request(REQ_NEXT, 32'hFFFF_FFFF);
		send_request(REQ_SEED, 32'hFFFF_FFFF);
		send_request(REQ_NEXT, 32'h0000_0000);
		send_request(REQ_NEXT, 32'hFFFF_FFFF);
	endtask

	// Each width code, including the unused one, seeded and stepped.
	task automatic test_each_width();
		logic [MODE_W-1:0] modes [4];
		int unsigned k;
		modes = '{MODE_64, MODE_96, MODE_128, MODE_UNUSED};
		for (k = 0; k < 4; k++) begin
			write_width_mode(modes[k]);
			send_request(REQ_SEED, $urandom());
			send_request(REQ_NEXT, $urandom());
			send_request(REQ_NEXT, $urandom());
		end
	endtask

	// Widening without a reseed uses the upper words as they stand.
	task automatic test_width_change_stale_words();
		write_width_mode(MODE_64);
		send_request(REQ_SEED, 32'h8000_0001);
		send_request(REQ_NEXT, 32'h7FFF_FFFE);
		write_width_mode(MODE_128);
		send_request(REQ_NEXT, $urandom());
		send_request(REQ_NEXT, $urandom());
	endtask

	// Mostly next requests in runs under random widths, with occasional reseeds
	// and occasional pauses until all results are back.
	task automatic test_random_traffic(input int unsigned item_total);
		int unsigned sent;
		int unsigned run_len;
		int unsigned n;
		sent = 0;
		while (sent < item_total) begin
			write_width_mode(MODE_W'($urandom_range(3)));
			if ($urandom_range(99) < 80) begin
				send_request(REQ_SEED, $urandom());
				sent++;
			end
			run_len = $urandom_range(40, 90);
			for (n = 0; n < run_len && sent < item_total; n++) begin
				if ($urandom_range(99) < 8)
					send_request(REQ_SEED, $urandom());
				else
					send_request(REQ_NEXT, $urandom());
				sent++;
				if ($urandom_range(99) < 2)
					drain_results();
			end
		end
	endtask

	// Accept results and compare each with the oldest expected word.
	always @(posedge clk) begin : check_results
		logic [WORD_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected random_value transaction, expected none, actual %08h",
					$time, random_value);
				error_count++;
			end else begin
				want = expected_words.pop_front();
				if (random_value !== want) begin
					$display("%0t: random_value mismatch, expected %08h, actual %08h",
						$time, want, random_value);
					error_count++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// End the run if no transaction of any kind happens for too long.
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Reset, directed tests, then random traffic under three idling profiles.
	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		req_type <= REQ_SEED;
		seed_value <= '0;
		gen_words = '{default: '0};
		width_cfg = MODE_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unseeded_zeros();
		test_seed_extremes();
		test_each_width();
		test_width_change_stale_words();

		test_random_traffic(ITEMS_PER_PHASE);
		send_idle_pct = 75;
		recv_stall_pct = 33;
		test_random_traffic(ITEMS_PER_PHASE);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(ITEMS_PER_PHASE);

		wait_idle();
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
